// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mkst_pkg.sv =====
// Types and constants of the MIDI keyboard split and transpose block.
`timescale 1ns / 1ps

package mkst_pkg;

   typedef logic [2:0] msg_type_type;
   typedef logic [1:0] mode_type;
   typedef logic [4:0] shift_type;

   localparam msg_type_type MSG_NOTE_OFF  = 3'd0;
   localparam msg_type_type MSG_NOTE_ON   = 3'd1;
   localparam msg_type_type MSG_CTRL      = 3'd2;
   localparam msg_type_type MSG_BEND      = 3'd3;
   localparam msg_type_type MSG_PROGRAM   = 3'd4;
   localparam msg_type_type MSG_TOUCH     = 3'd5;

   localparam msg_type_type OUT_NOTE_OFF  = 3'd0;
   localparam msg_type_type OUT_NOTE_ON   = 3'd1;
   localparam msg_type_type OUT_CTRL      = 3'd2;
   localparam msg_type_type OUT_BEND      = 3'd3;
   localparam msg_type_type OUT_TOUCH     = 3'd4;

   localparam mode_type MODE_IDLE  = 2'd0;
   localparam mode_type MODE_ARMED = 2'd1;
   localparam mode_type MODE_SPLIT = 2'd2;

   localparam logic [2:0] PROG_ARM       = 3'd0;
   localparam logic [2:0] PROG_SPLIT     = 3'd1;
   localparam logic [2:0] PROG_LEFT_DN   = 3'd2;
   localparam logic [2:0] PROG_LEFT_NONE = 3'd3;
   localparam logic [2:0] PROG_LEFT_UP   = 3'd4;
   localparam logic [2:0] PROG_RIGHT_DN  = 3'd5;
   localparam logic [2:0] PROG_RIGHT_NONE = 3'd6;
   localparam logic [2:0] PROG_RIGHT_UP  = 3'd7;

   localparam shift_type SHIFT_DOWN = 5'b10100;
   localparam shift_type SHIFT_NONE = 5'b00000;
   localparam shift_type SHIFT_UP   = 5'b01100;

   localparam logic [6:0] NOTE_TOP = 7'd127;
   localparam int KEYS = 128;

endpackage

// ===== design/midi_keyboard_split_transpose.sv =====
// Top level of the MIDI keyboard split and transpose block.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | msg_type, port, channel, data1, data2
//   rsp_    | out       | rsp_valid/rsp_stall  | out_type, out_port, out_channel,
//           |           |                      | out_data1, out_data2, last
//
// An accepted word is registered with its key table entry read from the synchronous
// memory; the processing stage then handles it and fills the output register.
// One word per cycle is sustained while the output is not stalled; duplicated
// controller, bend and aftertouch words hold the stage for a second output word.
// A stalled output register holds the processing stage, which then stalls input.
// Synchronous reset clears mode, transposes, key valid bits; split resets to 127.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module midi_keyboard_split_transpose (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mkst_pkg::msg_type_type req_msg_type,
   input  logic [7:0]            req_port,
   input  logic [3:0]            req_channel,
   input  logic [6:0]            req_data1,
   input  logic [6:0]            req_data2,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mkst_pkg::msg_type_type rsp_out_type,
   output logic [7:0]            rsp_out_port,
   output logic [3:0]            rsp_out_channel,
   output logic [6:0]            rsp_out_data1,
   output logic [6:0]            rsp_out_data2,
   output logic                  rsp_last
);
   import mkst_pkg::*;

   logic [10:0]    key_mem [KEYS];
   logic [KEYS-1:0] key_vld_ff;
   logic [10:0]    rd_ff;
   logic           fwd_ff;
   logic [10:0]    fwd_data_ff;

   logic           s1_valid_ff;
   logic           phase_ff;
   msg_type_type   s1_type_ff;
   logic [7:0]     s1_port_ff;
   logic [3:0]     s1_chn_ff;
   logic [6:0]     s1_d1_ff;
   logic [6:0]     s1_d2_ff;

   mode_type       mode_ff, mode_in;
   logic [6:0]     split_ff, split_in;
   shift_type      left_ff, left_in;
   shift_type      right_ff, right_in;

   logic           rsp_valid_ff;
   msg_type_type   rsp_type_ff, rsp_type_in;
   logic [7:0]     rsp_port_ff;
   logic [3:0]     rsp_chn_ff, rsp_chn_in;
   logic [6:0]     rsp_d1_ff, rsp_d1_in;
   logic [6:0]     rsp_d2_ff, rsp_d2_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           accept;
   logic           out_free;
   logic           has_res;
   logic           need_second;
   logic           step;
   logic           s1_done;
   logic           wr_en;
   logic [10:0]    wr_data;
   logic [10:0]    entry;
   logic           entry_vld;
   logic           dup;
   logic           upper;
   shift_type      shift;
   logic [8:0]     sum;
   logic [3:0]     map_chn;
   logic [6:0]     map_note;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign entry     = fwd_ff ? fwd_data_ff : rd_ff;
   assign entry_vld = key_vld_ff[s1_d1_ff];
   assign dup       = split_ff < NOTE_TOP;
   assign upper     = s1_d1_ff > split_ff;
   assign shift     = upper ? right_ff : left_ff;
   assign sum       = {2'b00, s1_d1_ff} + {{4{shift[4]}}, shift};
   assign map_chn   = upper ? s1_chn_ff + 4'd1 : s1_chn_ff;
   assign map_note  = (sum[8:7] == 2'b00) ? sum[6:0] : s1_d1_ff;

   always_comb begin
      has_res     = 1'b0;
      need_second = 1'b0;
      wr_en       = 1'b0;
      wr_data     = {map_chn, map_note};
      mode_in     = mode_ff;
      split_in    = split_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      rsp_type_in = s1_type_ff;
      rsp_chn_in  = s1_chn_ff;
      rsp_d1_in   = s1_d1_ff;
      rsp_d2_in   = s1_d2_ff;
      rsp_last_in = 1'b1;
      unique case (s1_type_ff) inside
         MSG_NOTE_OFF: begin
            has_res     = 1'b1;
            rsp_type_in = OUT_NOTE_OFF;
            if (entry_vld) begin
               rsp_chn_in = entry[10:7];
               rsp_d1_in  = entry[6:0];
            end
         end
         MSG_NOTE_ON: begin
            rsp_type_in = OUT_NOTE_ON;
            if (mode_ff == MODE_SPLIT) begin
               split_in = s1_d1_ff;
               mode_in  = MODE_IDLE;
            end else if (s1_d2_ff != 7'd0) begin
               has_res    = 1'b1;
               wr_en      = 1'b1;
               rsp_chn_in = map_chn;
               rsp_d1_in  = map_note;
            end else begin
               has_res = 1'b1;
               if (entry_vld) begin
                  rsp_chn_in = entry[10:7];
                  rsp_d1_in  = entry[6:0];
               end
            end
         end
         MSG_CTRL, MSG_BEND, MSG_TOUCH: begin
            has_res = 1'b1;
            if (s1_type_ff == MSG_TOUCH) begin
               rsp_type_in = OUT_TOUCH;
               rsp_d2_in   = 7'd0;
            end
            if (phase_ff) begin
               rsp_chn_in = s1_chn_ff + 4'd1;
            end else begin
               need_second = dup;
               rsp_last_in = !dup;
            end
         end
         MSG_PROGRAM: begin
            unique case (s1_d1_ff[2:0])
               PROG_ARM: mode_in = MODE_ARMED;
               PROG_SPLIT: begin
                  if (mode_ff == MODE_ARMED) begin
                     mode_in = MODE_SPLIT;
                  end
               end
               PROG_LEFT_DN: begin
                  left_in = SHIFT_DOWN;
                  mode_in = MODE_IDLE;
               end
               PROG_LEFT_NONE: begin
                  left_in = SHIFT_NONE;
                  mode_in = MODE_IDLE;
               end
               PROG_LEFT_UP: begin
                  left_in = SHIFT_UP;
                  mode_in = MODE_IDLE;
               end
               PROG_RIGHT_DN: begin
                  right_in = SHIFT_DOWN;
                  mode_in  = MODE_IDLE;
               end
               PROG_RIGHT_NONE: begin
                  right_in = SHIFT_NONE;
                  mode_in  = MODE_IDLE;
               end
               default: begin
                  right_in = SHIFT_UP;
                  mode_in  = MODE_IDLE;
               end
            endcase
         end
         default: has_res = 1'b0;
      endcase
   end

   assign step      = s1_valid_ff && (!has_res || out_free);
   assign s1_done   = step && !need_second;
   assign req_stall = s1_valid_ff && !s1_done;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (step && !phase_ff && wr_en) begin
         key_mem[s1_d1_ff] <= wr_data;
      end
      if (accept) begin
         rd_ff       <= key_mem[req_data1];
         fwd_ff      <= step && !phase_ff && wr_en && (req_data1 == s1_d1_ff);
         fwd_data_ff <= wr_data;
         s1_type_ff  <= req_msg_type;
         s1_port_ff  <= req_port;
         s1_chn_ff   <= req_channel;
         s1_d1_ff    <= req_data1;
         s1_d2_ff    <= req_data2;
      end
      if (step && has_res) begin
         rsp_type_ff <= rsp_type_in;
         rsp_port_ff <= s1_port_ff;
         rsp_chn_ff  <= rsp_chn_in;
         rsp_d1_ff   <= rsp_d1_in;
         rsp_d2_ff   <= rsp_d2_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         split_ff     <= NOTE_TOP;
         left_ff      <= SHIFT_NONE;
         right_ff     <= SHIFT_NONE;
      end else begin
         if (step && !phase_ff) begin
            mode_ff  <= mode_in;
            split_ff <= split_in;
            left_ff  <= left_in;
            right_ff <= right_in;
            if (wr_en) begin
               key_vld_ff[s1_d1_ff] <= 1'b1;
            end
         end
         if (step) begin
            phase_ff <= need_second;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (step && has_res) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_out_port    = rsp_port_ff;
   assign rsp_out_channel = rsp_chn_ff;
   assign rsp_out_data1   = rsp_d1_ff;
   assign rsp_out_data2   = rsp_d2_ff;
   assign rsp_last        = rsp_last_ff;

   `ASSERT_IMPLIES(a_phase_busy, clock, reset, phase_ff, s1_valid_ff,
                   "second word without a stage item")
   `ASSERT_IMPLIES(a_empty_ready, clock, reset, !s1_valid_ff, !req_stall,
                   "input stalled with an empty stage")
   `ASSERT_NEXT(a_accept_fills, clock, reset, accept, s1_valid_ff,
                "accepted word lost from the stage")
   `ASSERT_NEXT(a_dup_follows, clock, reset, rsp_valid_ff && !rsp_last_ff && !rsp_stall,
                rsp_valid_ff, "duplicate word did not follow")

endmodule
